[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[rtl/core/mrra_pkg.sv]
// Shared types, constants and microcode table of the message region ring allocator.
// Depends on nothing; used by the top level and its port checker.
package mrra_pkg;

    // Buffer and queue geometry
    localparam int BUFFER_BYTES = 2048;
    localparam int MAX_PENDING  = 10;
    localparam int SIZE_W       = 11;
    localparam int LAST_W       = 12;
    localparam int STATUS_W     = 2;
    localparam int EVICT_W      = 4;
    localparam int PTR_W        = $clog2(MAX_PENDING);
    localparam int CNT_W        = $clog2(MAX_PENDING + 1);

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_TAKE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Sequencer step addresses
    typedef logic [2:0] t_pc;
    localparam t_pc STEP_WAIT    = 3'd0;
    localparam t_pc STEP_DECODE  = 3'd1;
    localparam t_pc STEP_READ    = 3'd2;
    localparam t_pc STEP_ADVANCE = 3'd3;
    localparam t_pc STEP_EMIT    = 3'd4;

    // Datapath operation of one step
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_DECODE,
        OP_LOAD,
        OP_ADVANCE,
        OP_EMIT
    } t_op;

    // Jump condition of one step
    typedef enum logic [1:0] {
        C_IN_XFER,
        C_EARLY,
        C_EVICT,
        C_OUT_BUSY
    } t_cond;

    // One control word: operation, condition, target when true, target when false
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   nxt_t;
        t_pc   nxt_f;
    } t_ctrl;

    // Microcode table
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        case (pc)
            STEP_WAIT:    w = '{OP_ACCEPT,  C_IN_XFER,  STEP_DECODE, STEP_WAIT};
            STEP_DECODE:  w = '{OP_DECODE,  C_EARLY,    STEP_EMIT,   STEP_READ};
            STEP_READ:    w = '{OP_LOAD,    C_EARLY,    STEP_ADVANCE, STEP_ADVANCE};
            STEP_ADVANCE: w = '{OP_ADVANCE, C_EVICT,    STEP_READ,   STEP_EMIT};
            STEP_EMIT:    w = '{OP_EMIT,    C_OUT_BUSY, STEP_EMIT,   STEP_WAIT};
            default:      w = '{OP_ACCEPT,  C_IN_XFER,  STEP_DECODE, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/message_region_ring_allocator.sv]
// Top level of the message region ring allocator: microcoded sequencer and datapath.
// Depends on mrra_pkg for geometry, codes and the microcode table.
//
// Places each new message of i_req_size bytes at the running start offset of a
// 2048-byte receive buffer and queues its descriptor in a ring of ten entries;
// a take request pops the oldest descriptor. Pending regions whose bounds
// enclose the new region's last byte are dropped oldest first and counted in
// o_evicted_count. One item is handled at a time. A take on an empty queue or
// a request of zero size or of 2048 bytes or more goes from decode straight to
// emit; any other take or allocation passes through the read and advance
// steps, once more per evicted descriptor (up to ten): the eviction loop reads
// and tests one ring entry in two microcode steps over the single ring read port.
// The next item is taken in the cycle after the result register is loaded,
// even while that result still waits for its output transfer.
`default_nettype none

module message_region_ring_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_action,
    input  wire logic [mrra_pkg::SIZE_W-1:0]     i_req_size,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [mrra_pkg::STATUS_W-1:0]        o_status,
    output logic [mrra_pkg::SIZE_W-1:0]          o_region_start,
    output logic [mrra_pkg::SIZE_W-1:0]          o_region_size,
    output logic [mrra_pkg::EVICT_W-1:0]         o_evicted_count
);

    // Descriptor ring
    logic [mrra_pkg::SIZE_W-1:0] r_ent_start [mrra_pkg::MAX_PENDING];
    logic [mrra_pkg::LAST_W-1:0] r_ent_last  [mrra_pkg::MAX_PENDING];
    logic [mrra_pkg::SIZE_W-1:0] r_ent_len   [mrra_pkg::MAX_PENDING];

    // Control state
    mrra_pkg::t_pc               r_pc;
    mrra_pkg::t_pc               n_pc;
    logic [mrra_pkg::PTR_W-1:0]  r_head;
    logic [mrra_pkg::CNT_W-1:0]  r_count;
    logic [mrra_pkg::SIZE_W-1:0] r_next_start;
    logic                        r_out_valid;

    // Datapath registers
    logic                          r_action;
    logic [mrra_pkg::SIZE_W-1:0]   r_size;
    logic [mrra_pkg::LAST_W-1:0]   r_last;
    logic [mrra_pkg::SIZE_W-1:0]   r_hs;
    logic [mrra_pkg::LAST_W-1:0]   r_hl;
    logic [mrra_pkg::SIZE_W-1:0]   r_hlen;
    logic [mrra_pkg::STATUS_W-1:0] r_status;
    logic [mrra_pkg::SIZE_W-1:0]   r_rstart;
    logic [mrra_pkg::SIZE_W-1:0]   r_rsize;
    logic [mrra_pkg::EVICT_W-1:0]  r_evict;
    logic [mrra_pkg::STATUS_W-1:0] r_o_status;
    logic [mrra_pkg::SIZE_W-1:0]   r_o_start;
    logic [mrra_pkg::SIZE_W-1:0]   r_o_size;
    logic [mrra_pkg::EVICT_W-1:0]  r_o_evict;

    mrra_pkg::t_ctrl               w_ctrl;
    logic                          w_take;
    logic                          w_empty;
    logic                          w_bad;
    logic                          w_early;
    logic                          w_inside;
    logic                          w_evict;
    logic                          w_full;
    logic                          w_push;
    logic                          w_pop;
    logic                          w_cond;
    logic                          w_in_xfer;
    logic                          w_out_busy;
    logic                          w_emit;
    logic [mrra_pkg::PTR_W:0]      w_tail_sum;
    logic [mrra_pkg::PTR_W-1:0]    w_tail;
    logic [mrra_pkg::PTR_W-1:0]    w_head_inc;
    logic [mrra_pkg::LAST_W:0]     w_last_inc;
    logic [mrra_pkg::SIZE_W-1:0]   w_next_start;
    logic [mrra_pkg::LAST_W-1:0]   w_last;

    // Fetch the control word of the current step
    assign w_ctrl = mrra_pkg::ucode(r_pc);

    // Handshakes
    assign o_ready    = (r_pc == mrra_pkg::STEP_WAIT);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_busy = r_out_valid && !i_ready;
    assign w_emit     = (w_ctrl.op == mrra_pkg::OP_EMIT) && !w_out_busy;

    // Decode request and test oldest region
    assign w_take   = (r_action == mrra_pkg::ACT_TAKE);
    assign w_empty  = (r_count == '0);
    assign w_bad    = (r_size == '0)
                   || ({1'b0, r_size} >= mrra_pkg::LAST_W'(mrra_pkg::BUFFER_BYTES));
    assign w_early  = w_take ? w_empty : w_bad;
    assign w_inside = !w_empty
                   && ((r_last > {1'b0, r_hs} && r_last < r_hl)
                    || (r_last < {1'b0, r_hs} && r_last > r_hl));
    assign w_evict  = !w_take && w_inside;
    assign w_full   = (r_count >= mrra_pkg::CNT_W'(mrra_pkg::MAX_PENDING));
    assign w_pop    = (w_ctrl.op == mrra_pkg::OP_ADVANCE) && (w_take || w_inside);
    assign w_push   = (w_ctrl.op == mrra_pkg::OP_ADVANCE) && !w_take && !w_inside
                   && !w_full;

    // Ring pointer arithmetic
    assign w_tail_sum = {1'b0, r_head} + (mrra_pkg::PTR_W + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= (mrra_pkg::PTR_W + 1)'(mrra_pkg::MAX_PENDING))
                      ? mrra_pkg::PTR_W'(w_tail_sum - (mrra_pkg::PTR_W + 1)'(mrra_pkg::MAX_PENDING))
                      : w_tail_sum[mrra_pkg::PTR_W-1:0];
    assign w_head_inc = (r_head == mrra_pkg::PTR_W'(mrra_pkg::MAX_PENDING - 1))
                      ? '0 : r_head + 1'b1;

    // Last byte of the new region and the following start offset
    assign w_last       = mrra_pkg::LAST_W'({1'b0, r_next_start} + {1'b0, r_size} - 1'b1);
    assign w_last_inc   = {1'b0, r_last} + 1'b1;
    assign w_next_start = (w_last_inc < (mrra_pkg::LAST_W + 1)'(mrra_pkg::BUFFER_BYTES))
                        ? w_last_inc[mrra_pkg::SIZE_W-1:0] : '0;

    // Select the jump condition and the next step
    always_comb begin
        case (w_ctrl.cond)
            mrra_pkg::C_IN_XFER:  w_cond = w_in_xfer;
            mrra_pkg::C_EARLY:    w_cond = w_early;
            mrra_pkg::C_EVICT:    w_cond = w_evict;
            mrra_pkg::C_OUT_BUSY: w_cond = w_out_busy;
            default:              w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_ctrl.nxt_t : w_ctrl.nxt_f;
    end

    // Hold step counter, ring pointers and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= mrra_pkg::STEP_WAIT;
            r_head       <= '0;
            r_count      <= '0;
            r_next_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_pop) begin
                r_head  <= w_head_inc;
                r_count <= r_count - 1'b1;
            end
            if (w_push) begin
                r_count      <= r_count + 1'b1;
                r_next_start <= w_next_start;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Write ring entry on push
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent_start[w_tail] <= r_next_start;
            r_ent_last[w_tail]  <= r_last;
            r_ent_len[w_tail]   <= r_size;
        end
    end

    // Read oldest entry
    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == mrra_pkg::OP_LOAD) begin
            r_hs   <= r_ent_start[r_head];
            r_hl   <= r_ent_last[r_head];
            r_hlen <= r_ent_len[r_head];
        end
    end

    // Datapath operations per step
    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            mrra_pkg::OP_ACCEPT: begin
                if (w_in_xfer) begin
                    r_action <= i_action;
                    r_size   <= i_req_size;
                end
            end
            mrra_pkg::OP_DECODE: begin
                r_last   <= w_last;
                r_rstart <= '0;
                r_rsize  <= '0;
                r_evict  <= '0;
                if (w_take) begin
                    r_status <= w_empty ? mrra_pkg::ST_EMPTY : mrra_pkg::ST_OK;
                end else begin
                    r_status <= w_bad ? mrra_pkg::ST_BADSIZE : mrra_pkg::ST_OK;
                end
            end
            mrra_pkg::OP_ADVANCE: begin
                if (w_take) begin
                    r_rstart <= r_hs;
                    r_rsize  <= r_hlen;
                end else if (w_inside) begin
                    r_evict <= r_evict + 1'b1;
                end else if (w_full) begin
                    r_status <= mrra_pkg::ST_FULL;
                end else begin
                    r_rstart <= r_next_start;
                    r_rsize  <= r_size;
                end
            end
            mrra_pkg::OP_EMIT: begin
                if (w_emit) begin
                    r_o_status <= r_status;
                    r_o_start  <= r_rstart;
                    r_o_size   <= r_rsize;
                    r_o_evict  <= r_evict;
                end
            end
            default: begin
            end
        endcase
    end

    // Drive result ports
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_region_start  = r_o_start;
    assign o_region_size   = r_o_size;
    assign o_evicted_count = r_o_evict;

endmodule

`default_nettype wire

[rtl/core/mrra_checker.sv]
// Port checker of the message region ring allocator, bound to the top level.
// Depends on mrra_pkg for status codes and on assert_macros.svh.
`include "assert_macros.svh"

module mrra_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            i_action,
    input logic [mrra_pkg::SIZE_W-1:0]     i_req_size,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [mrra_pkg::STATUS_W-1:0]   o_status,
    input logic [mrra_pkg::SIZE_W-1:0]     o_region_start,
    input logic [mrra_pkg::SIZE_W-1:0]     o_region_size,
    input logic [mrra_pkg::EVICT_W-1:0]    o_evicted_count
);

    // No result right after reset
    `ASSERT_ALWAYS(a_no_valid_after_reset, i_clk, !i_rst_n |=> !o_valid)

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_region_start)
            && $stable(o_region_size) && $stable(o_evicted_count))

    // Empty-queue and bad-size results carry an empty region and no evictions
    `ASSERT_CLK(a_reject_zero, i_clk, i_rst_n,
        o_valid && (o_status == mrra_pkg::ST_EMPTY || o_status == mrra_pkg::ST_BADSIZE)
            |-> o_region_start == '0 && o_region_size == '0 && o_evicted_count == '0)

    // A successful result names a non-empty region
    `ASSERT_CLK(a_ok_size, i_clk, i_rst_n,
        o_valid && o_status == mrra_pkg::ST_OK |-> o_region_size != '0)

    // A full queue result carries no region
    `ASSERT_CLK(a_full_zero, i_clk, i_rst_n,
        o_valid && o_status == mrra_pkg::ST_FULL |-> o_region_start == '0 && o_region_size == '0)

endmodule

bind message_region_ring_allocator mrra_checker u_mrra_checker (.*);
